@@ design/tpld_pkg.sv @@
// ----------------------------------------------------------------------------
// tpld_pkg
// Shared types and constants of the tape pulse length decoder.
// ----------------------------------------------------------------------------
package tpld_pkg;

	localparam int unsigned PosW      = 32;
	localparam int unsigned CodeW     = 24;
	localparam int unsigned ScaleW    = 22;
	localparam int unsigned FracBits  = 16;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned ProdW     = CodeW + ScaleW;
	localparam int unsigned ScaledW   = ProdW - FracBits;

	localparam logic [CodeW-1:0]  ZeroCodeTicks = CodeW'(256);
	localparam logic [ScaleW-1:0] UnityScale    = ScaleW'(65536);
	localparam logic [PosW-1:0]   PosMax        = '1;

	// Image format codes
	typedef enum logic [1:0] {
		FMT_V0   = 2'd0,
		FMT_V1   = 2'd1,
		FMT_HALF = 2'd2,
		FMT_RSVD = 2'd3
	} fmt_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DATA_LENGTH = 2'd0,
		REG_FORMAT      = 2'd1,
		REG_SHORT_SCALE = 2'd2,
		REG_LONG_SCALE  = 2'd3
	} reg_idx_t;

	// Collection phase of a long pulse
	typedef enum logic [1:0] {
		PH_PULSE = 2'd0,
		PH_LEN0  = 2'd1,
		PH_LEN1  = 2'd2,
		PH_LEN2  = 2'd3
	} phase_t;

	// One decoded pulse on its way to the multiplier
	typedef struct packed {
		logic [CodeW-1:0]  code;
		logic [ScaleW-1:0] scale;
		logic              eod;
	} tpld_item_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [PosW-1:0]   data_length;
		fmt_t              format_version;
		logic [ScaleW-1:0] short_scale;
		logic [ScaleW-1:0] long_scale;
	} tpld_cfg_t;

endpackage

@@ design/tape_pulse_length_decoder.sv @@
// ----------------------------------------------------------------------------
// tape_pulse_length_decoder
// Turns tape image pulse bytes into pulse durations in timer ticks.
// ----------------------------------------------------------------------------
// Pipeline: the byte that completes a pulse loads stage 1; the scaled time then loads the result register.
// Throughput: one byte per cycle while out_stall does not hold the result;
// a single 24x22 multiplier sits between the stage 1 and result registers.
// Reset: clears position, phase, pipeline valids and all configuration
// registers (length 0, format 0, both scales 1.0).
module tape_pulse_length_decoder import tpld_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [PosW-1:0]   cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [TimeW-1:0]  pulse_time,
	output logic              end_of_data
);

	tpld_cfg_t  cfg_q;
	logic       valid_s1;
	tpld_item_t item_s1;
	logic       take_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_length    <= '0;
			cfg_q.format_version <= FMT_V0;
			cfg_q.short_scale    <= UnityScale;
			cfg_q.long_scale     <= UnityScale;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DATA_LENGTH: cfg_q.data_length    <= cfg_wdata;
				REG_FORMAT:      cfg_q.format_version <= fmt_t'(cfg_wdata[1:0]);
				REG_SHORT_SCALE: cfg_q.short_scale    <= cfg_wdata[ScaleW-1:0];
				REG_LONG_SCALE:  cfg_q.long_scale     <= cfg_wdata[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	tpld_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.take_s1   (take_s1),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	tpld_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.format_version (cfg_q.format_version),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.take_s1        (take_s1),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pulse_time     (pulse_time),
		.end_of_data    (end_of_data)
	);

endmodule

@@ design/tpld_decode.sv @@
// ----------------------------------------------------------------------------
// tpld_decode
// Byte stream parser: tracks position and long-pulse collection, and registers
// one code/scale pair per pulse, or an end-of-data item, into stage 1.
// ----------------------------------------------------------------------------
module tpld_decode import tpld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tpld_cfg_t  cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       take_s1,
	output logic       valid_s1,
	output tpld_item_t item_s1
);

	logic [PosW-1:0] byte_position_q;
	phase_t          collect_phase_q;
	logic [15:0]     long_low_q;

	logic            accept;
	logic            emit;
	tpld_item_t      item_d;
	logic [PosW-1:0] pos_next;
	phase_t          phase_next;
	logic [15:0]     long_low_next;
	logic            advance;

	// Stage 1 frees up when it is empty or its item moves on
	assign in_stall = valid_s1 && !take_s1;
	assign accept   = in_valid && !in_stall;

	// Decode one byte against the current phase
	always_comb begin
		emit          = 1'b0;
		advance       = 1'b0;
		phase_next    = collect_phase_q;
		long_low_next = long_low_q;
		item_d.code   = '0;
		item_d.scale  = '0;
		item_d.eod    = 1'b0;
		unique case (collect_phase_q)
			PH_LEN0: begin
				advance       = 1'b1;
				long_low_next = {8'd0, data_byte};
				phase_next    = PH_LEN1;
			end
			PH_LEN1: begin
				advance       = 1'b1;
				long_low_next = {data_byte, long_low_q[7:0]};
				phase_next    = PH_LEN2;
			end
			PH_LEN2: begin
				advance      = 1'b1;
				phase_next   = PH_PULSE;
				emit         = 1'b1;
				item_d.code  = {data_byte, long_low_q};
				item_d.scale = cfg.long_scale;
			end
			PH_PULSE: begin
				if (byte_position_q >= cfg.data_length) begin
					emit       = 1'b1;
					item_d.eod = 1'b1;
				end else if (data_byte != 8'd0) begin
					advance      = 1'b1;
					emit         = 1'b1;
					item_d.code  = {16'd0, data_byte};
					item_d.scale = cfg.short_scale;
				end else if (cfg.format_version == FMT_V0) begin
					advance      = 1'b1;
					emit         = 1'b1;
					item_d.code  = ZeroCodeTicks;
					item_d.scale = UnityScale;
				end else begin
					advance    = 1'b1;
					phase_next = PH_LEN0;
				end
			end
			default: begin
				phase_next = PH_PULSE;
			end
		endcase
	end

	// Saturating byte count
	assign pos_next = (byte_position_q == PosMax) ? byte_position_q
	                                              : byte_position_q + PosW'(1);

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			collect_phase_q <= PH_PULSE;
			long_low_q      <= '0;
		end else if (accept) begin
			if (advance) begin
				byte_position_q <= pos_next;
			end
			collect_phase_q <= phase_next;
			long_low_q      <= long_low_next;
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ design/tpld_scale.sv @@
// ----------------------------------------------------------------------------
// tpld_scale
// Fixed-point scaling of one pulse code and the result register.
// ----------------------------------------------------------------------------
module tpld_scale import tpld_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fmt_t             format_version,
	input  logic             valid_s1,
	input  tpld_item_t       item_s1,
	output logic             take_s1,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [TimeW-1:0] pulse_time,
	output logic             end_of_data
);

	logic [ProdW-1:0]   product;
	logic [ScaledW-1:0] scaled;
	logic [TimeW-1:0]   finished;
	logic               load_s2;

	// Q6.16 multiply, truncate the fraction
	assign product = ProdW'(item_s1.code) * ProdW'(item_s1.scale);
	assign scaled  = product[ProdW-1:FracBits];

	// Double for half-wave images; the scaled value stays below 2^30,
	// so the doubled time always fits in the 32-bit result
	assign finished = (format_version == FMT_HALF) ? TimeW'({scaled, 1'b0})
	                                               : TimeW'(scaled);

	assign take_s1 = !out_valid || !out_stall;
	assign load_s2 = valid_s1 && take_s1;

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take_s1) begin
			out_valid <= valid_s1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_s2) begin
			pulse_time  <= finished;
			end_of_data <= item_s1.eod;
		end
	end

endmodule

@@ design/tpld_checker.sv @@
// ----------------------------------------------------------------------------
// tpld_checker
// Port-level checks of the tape pulse length decoder.
// ----------------------------------------------------------------------------
module tpld_checker import tpld_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [TimeW-1:0] pulse_time,
	input logic             end_of_data
);

	// End of data carries no duration
	a_eod_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_data |-> pulse_time == '0)
		else $error("end_of_data with nonzero pulse_time");

	// Scaled times never reach the top bit
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !pulse_time[TimeW-1])
		else $error("pulse_time out of range");

	// An empty result register never blocks input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pulse_time)
		&& $stable(end_of_data))
		else $error("stalled result changed");

endmodule

bind tape_pulse_length_decoder tpld_checker u_tpld_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pulse_time  (pulse_time),
	.end_of_data (end_of_data)
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the tape pulse length decoder. Bytes go in through the
// valid/stall channel while a local decoder model tracks position, the long
// pulse phase and the register values. Each result transfer is checked field
// by field against the oldest expected pulse. A short directed pass comes
// first, then randomized phases, each under its own register setting.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tpld_pkg::*;

	localparam int DrainCycles = 4;

	typedef struct packed {
		logic [TimeW-1:0] ticks;
		logic             eod;
	} pulse_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = REG_DATA_LENGTH;
	logic [PosW-1:0]  cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [7:0]       data_byte = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [TimeW-1:0] pulse_time;
	logic             end_of_data;

	// Register copies and decoder state as seen by the model
	logic [PosW-1:0]   cfg_len   = '0;
	fmt_t              cfg_fmt   = FMT_V0;
	logic [ScaleW-1:0] cfg_short = UnityScale;
	logic [ScaleW-1:0] cfg_long  = UnityScale;
	logic [PosW-1:0]   pos_count = '0;
	phase_t            collect   = PH_PULSE;
	logic [CodeW-1:0]  raw_len   = '0;

	pulse_t pending_pulses[$];

	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int stall_left = 0;
	int errors = 0;
	int n_checked = 0;
	int n_bytes = 0;
	int n_short = 0;
	int n_zero = 0;
	int n_long = 0;
	int n_eod = 0;

	tape_pulse_length_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pulse_time  (pulse_time),
		.end_of_data (end_of_data)
	);

	always #1 clk = ~clk;

	// Multiply a code by a Q6.16 scale and drop the fraction
	function automatic logic [63:0] apply_scale(logic [CodeW-1:0] code,
			logic [ScaleW-1:0] k);
		return (64'(code) * 64'(k)) >> FracBits;
	endfunction

	// Double in half-wave format, then clamp to the time range
	function automatic logic [TimeW-1:0] finish_ticks(logic [63:0] t);
		if (cfg_fmt == FMT_HALF) begin
			t = t << 1;
		end
		if (t > 64'hFFFF_FFFF) begin
			return '1;
		end
		return t[TimeW-1:0];
	endfunction

	function automatic void bump_position();
		if (pos_count != PosMax) begin
			pos_count = pos_count + 1'b1;
		end
	endfunction

	// Advance the decoder model by one accepted byte, queue any pulse it yields
	function automatic void decode_byte(logic [7:0] b);
		pulse_t p;
		n_bytes++;
		p.eod = 1'b0;
		if (collect != PH_PULSE) begin
			bump_position();
			raw_len = raw_len | (CodeW'(b) << (8 * (int'(collect) - 1)));
			if (collect != PH_LEN2) begin
				collect = phase_t'(collect + 2'd1);
				return;
			end
			collect = PH_PULSE;
			p.ticks = finish_ticks(apply_scale(raw_len, cfg_long));
			n_long++;
			pending_pulses.push_back(p);
			return;
		end
		if (pos_count >= cfg_len) begin
			p.ticks = '0;
			p.eod = 1'b1;
			n_eod++;
			pending_pulses.push_back(p);
			return;
		end
		bump_position();
		if (b != 8'h00) begin
			p.ticks = finish_ticks(apply_scale(CodeW'(b), cfg_short));
			n_short++;
			pending_pulses.push_back(p);
		end else if (cfg_fmt == FMT_V0) begin
			p.ticks = finish_ticks(64'(ZeroCodeTicks));
			n_zero++;
			pending_pulses.push_back(p);
		end else begin
			raw_len = '0;
			collect = PH_LEN0;
		end
	endfunction

	// Check result transfers and pace the output stall
	always @(posedge clk) begin
		pulse_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (pending_pulses.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result: expected none, got pulse_time %0d eod %0b",
					$time, pulse_time, end_of_data);
			end else begin
				want = pending_pulses.pop_front();
				if (pulse_time !== want.ticks) begin
					errors++;
					$display("%0t ns: pulse_time mismatch: expected %0d, got %0d",
						$time, want.ticks, pulse_time);
				end
				if (end_of_data !== want.eod) begin
					errors++;
					$display("%0t ns: end_of_data mismatch: expected %0b, got %0b",
						$time, want.eod, end_of_data);
				end
			end
			stall_left = recv_idle ? $urandom_range(0, 12) : 0;
			out_stall <= (stall_left != 0);
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	// Send one byte after a random gap (when send_idle is set) and hold it until the transfer
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_byte(b);
	endtask

	// Stop sending and let every expected pulse come out
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write one register once the decoder has gone quiet
	task automatic write_reg(input reg_idx_t idx, input logic [PosW-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DATA_LENGTH: cfg_len = v;
			REG_FORMAT:      cfg_fmt = fmt_t'(v[1:0]);
			REG_SHORT_SCALE: cfg_short = v[ScaleW-1:0];
			REG_LONG_SCALE:  cfg_long = v[ScaleW-1:0];
		endcase
	endtask

	// With no data length every pulse byte, zero or not, ends the data
	task automatic test_end_of_data_after_reset();
		write_reg(REG_DATA_LENGTH, '0);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// One-byte codes at unity, largest and zero scale, and the format 0 zero code
	task automatic test_short_codes();
		write_reg(REG_DATA_LENGTH, PosMax);
		write_reg(REG_FORMAT, 32'(FMT_V0));
		write_reg(REG_SHORT_SCALE, 32'(UnityScale));
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'h00);
		write_reg(REG_SHORT_SCALE, 32'h003F_FFFF);
		send_byte(8'hFF);
		write_reg(REG_SHORT_SCALE, '0);
		send_byte(8'h80);
	endtask

	// Long form at the largest raw length and scale, then the reserved format
	task automatic test_long_codes();
		write_reg(REG_FORMAT, 32'(FMT_V1));
		write_reg(REG_LONG_SCALE, 32'h003F_FFFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		write_reg(REG_FORMAT, 32'(FMT_RSVD));
		write_reg(REG_LONG_SCALE, 32'(UnityScale));
		send_byte(8'h00);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'hC3);
	endtask

	// Length bytes run past the data length; the next pulse byte ends the data
	task automatic test_length_limit();
		write_reg(REG_FORMAT, 32'(FMT_V1));
		write_reg(REG_DATA_LENGTH, pos_count + 1'b1);
		send_byte(8'h00);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		send_byte(8'h10);
	endtask

	// Switch to half-wave and a new long scale between length bytes
	task automatic test_format_mid_pulse();
		write_reg(REG_DATA_LENGTH, PosMax);
		write_reg(REG_FORMAT, 32'(FMT_V1));
		send_byte(8'h00);
		send_byte(8'h12);
		write_reg(REG_FORMAT, 32'(FMT_HALF));
		write_reg(REG_LONG_SCALE, 32'h003F_FFFF);
		send_byte(8'h34);
		send_byte(8'h56);
		send_byte(8'hFF);
	endtask

	function automatic logic [ScaleW-1:0] pick_scale();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return '1;
			2:       return UnityScale;
			default: return ScaleW'($urandom_range(0, 32'h003F_FFFF));
		endcase
	endfunction

	// Random phases of mostly well-formed pulses with some stray bytes
	task automatic test_random_stream(input int total);
		int per;
		int sent;
		int r;
		logic [PosW-1:0] len;
		per = total / 6;
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 3))
				0:       len = PosMax;
				1:       len = pos_count + PosW'($urandom_range(per / 4, per));
				2:       len = pos_count + PosW'(per * 2);
				default: len = pos_count + PosW'($urandom_range(0, per / 4));
			endcase
			write_reg(REG_DATA_LENGTH, len);
			write_reg(REG_FORMAT, 32'($urandom_range(0, 3)));
			write_reg(REG_SHORT_SCALE, 32'(pick_scale()));
			write_reg(REG_LONG_SCALE, 32'(pick_scale()));
			// first phase runs flat out on both sides
			send_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
			recv_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < per) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					send_byte(8'($urandom_range(1, 255)));
					sent++;
				end else if (r < 85) begin
					send_byte(8'h00);
					repeat (3) send_byte(8'($urandom_range(0, 255)));
					sent += 4;
				end else begin
					send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
					sent++;
				end
			end
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_end_of_data_after_reset();
		test_short_codes();
		test_long_codes();
		test_length_limit();
		test_format_mid_pulse();
		test_random_stream(1500);
		drain();
		if (pending_pulses.size() != 0) begin
			errors++;
			$display("%0t ns: %0d expected results never arrived", $time, pending_pulses.size());
		end
		$display("Fed %0d bytes: %0d short codes, %0d zero codes, %0d long pulses, %0d end-of-data.",
			n_bytes, n_short, n_zero, n_long, n_eod);
		$display("Checked %0d result transfers, %0d mismatches.", n_checked, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hard stop in case the decoder hangs
	initial begin
		#2_000_000;
		$display("Timeout: decoder stopped making progress");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
